/* rtl/soa_pkg.sv */
// ============================================================================
// soa_pkg
// Shared sizes and codes of the slab object allocator.
// ============================================================================
package soa_pkg;

  localparam int NUM_PAGES  = 64;
  localparam int PAGE_BYTES = 4096;
  localparam int MAX_SLOTS  = 512;

  localparam int PG_W      = $clog2(NUM_PAGES);
  localparam int LIST_W    = PG_W + 1;
  localparam int OFF_W     = $clog2(PAGE_BYTES);
  localparam int ADDR_W    = PG_W + OFF_W;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int LINK_W    = 10;
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int SIZE_W    = 12;
  localparam int MIN_SIZE  = 8;
  localparam int DIV_W     = OFF_W + 1;
  localparam int DSTEP_W   = $clog2(DIV_W);
  localparam int PROD_W    = SLOT_W + SIZE_W;
  localparam int PGW_W     = LINK_W + CNT_W;
  localparam int LINK_DEPTH = NUM_PAGES * MAX_SLOTS;

  localparam logic [LIST_W-1:0] LIST_EMPTY = LIST_W'(NUM_PAGES);

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_FREE    = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

endpackage

/* rtl/soa_ram.sv */
// ============================================================================
// soa_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module soa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/slab_object_allocator.sv */
// ============================================================================
// slab_object_allocator
// Slab allocator over a pool of pages with per-page LIFO slot free lists.
// ============================================================================
// Every transaction ends in a result strobe: an allocate from the cached or a
// partial page, an allocate from a fresh page, a failed allocate, or a free
// (slot divider plus table RMW).
// One transaction at a time; busy drops with the result strobe.
// Reset: synchronous; control state clears, object size returns to 8 and
// busy holds high for the slots-per-page division. No stalls.
module slab_object_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_action,
  input  logic [soa_pkg::ADDR_W-1:0] in_address,
  output logic                       out_valid,
  output logic                       out_status,
  output logic [soa_pkg::ADDR_W-1:0] out_object_address,
  output logic                       out_page_released,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [soa_pkg::SIZE_W-1:0] cfg_object_size
);

  typedef enum logic [4:0] {
    S_NDIV, S_IDLE,
    S_A_PGRD, S_A_PG, S_A_LKRD, S_A_LK, S_FRESH, S_SWEEP,
    S_F_DIV, S_F_PGRD, S_F_PG, S_F_REL,
    S_RM1, S_RM2, S_PUSH1, S_PUSH2,
    S_MUL, S_DONE
  } state_t;

  state_t                        state_r, ret_r;
  logic [soa_pkg::PG_W-1:0]      page_r;
  logic [soa_pkg::SLOT_W-1:0]    slot_r;
  logic [soa_pkg::CNT_W-1:0]     cnt_r;
  logic [soa_pkg::CNT_W-1:0]     idx_r;
  logic [soa_pkg::DIV_W-1:0]     rem_r, quo_r;
  logic [soa_pkg::DSTEP_W-1:0]   step_r;
  logic [soa_pkg::CNT_W-1:0]     n_r;
  logic [soa_pkg::SIZE_W-1:0]    size_r;
  logic [soa_pkg::LIST_W-1:0]    head_r;
  logic                          cached_v_r;
  logic [soa_pkg::PG_W-1:0]      cached_pg_r;
  logic [soa_pkg::NUM_PAGES-1:0] owned_r, inl_r;
  logic [soa_pkg::PG_W-1:0]      free_pg_r;
  logic                          free_any_r;
  logic [soa_pkg::PROD_W-1:0]    prod_r;
  logic                          addr_en_r, status_r, rel_r;
  logic                          out_valid_r, out_status_r, out_rel_r;
  logic [soa_pkg::ADDR_W-1:0]    out_addr_r;

  // ---- effective size and shared restoring divider step
  logic [soa_pkg::SIZE_W-1:0] eff;
  logic [soa_pkg::DIV_W-1:0]  trial, rem_step, quo_step;
  logic                       ge, div_last;

  assign eff = (size_r < soa_pkg::SIZE_W'(soa_pkg::MIN_SIZE)) ?
               soa_pkg::SIZE_W'(soa_pkg::MIN_SIZE) : size_r;
  assign trial    = {rem_r[soa_pkg::DIV_W-2:0], quo_r[soa_pkg::DIV_W-1]};
  assign ge       = trial >= soa_pkg::DIV_W'(eff);
  assign rem_step = ge ? trial - soa_pkg::DIV_W'(eff) : trial;
  assign quo_step = {quo_r[soa_pkg::DIV_W-2:0], ge};
  assign div_last = step_r == soa_pkg::DSTEP_W'(soa_pkg::DIV_W - 1);

  // ---- lowest unowned page, registered from the owned bits
  logic [soa_pkg::PG_W-1:0] free_pg;
  logic                     free_any;
  always_comb begin
    free_pg  = '0;
    free_any = 1'b0;
    for (int i = soa_pkg::NUM_PAGES - 1; i >= 0; i--) begin
      if (!owned_r[i]) begin
        free_pg  = soa_pkg::PG_W'(i);
        free_any = 1'b1;
      end
    end
  end

  // ---- memories
  logic                             lk_we;
  logic [$clog2(soa_pkg::LINK_DEPTH)-1:0] lk_waddr, lk_raddr;
  logic [soa_pkg::LINK_W-1:0]       lk_wdata, lk_rd;
  logic                             pg_we;
  logic [soa_pkg::PGW_W-1:0]        pg_wdata, pg_rd;
  logic [soa_pkg::PG_W-1:0]         pg_waddr;
  logic                             nx_we, pv_we;
  logic [soa_pkg::PG_W-1:0]         nx_waddr, pv_waddr;
  logic [soa_pkg::LIST_W-1:0]       nx_wdata, pv_wdata, nx_rd, pv_rd;

  soa_ram #(.WIDTH(soa_pkg::LINK_W), .DEPTH(soa_pkg::LINK_DEPTH)) u_link (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(lk_raddr), .rdata(lk_rd));
  soa_ram #(.WIDTH(soa_pkg::PGW_W), .DEPTH(soa_pkg::NUM_PAGES)) u_page (
    .clk(clk), .we(pg_we), .waddr(pg_waddr), .wdata(pg_wdata),
    .raddr(page_r), .rdata(pg_rd));
  soa_ram #(.WIDTH(soa_pkg::LIST_W), .DEPTH(soa_pkg::NUM_PAGES)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(page_r), .rdata(nx_rd));
  soa_ram #(.WIDTH(soa_pkg::LIST_W), .DEPTH(soa_pkg::NUM_PAGES)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(page_r), .rdata(pv_rd));

  // Page word fields
  logic [soa_pkg::LINK_W-1:0] pg_head;
  logic [soa_pkg::CNT_W-1:0]  pg_cnt, cnt_inc;
  logic [soa_pkg::CNT_W:0]    idx_inc;
  assign pg_head = pg_rd[soa_pkg::PGW_W-1:soa_pkg::CNT_W];
  assign pg_cnt  = pg_rd[soa_pkg::CNT_W-1:0];
  assign cnt_inc = pg_cnt + soa_pkg::CNT_W'(1);
  assign idx_inc = {1'b0, idx_r} + (soa_pkg::CNT_W + 1)'(1);

  assign lk_raddr = {page_r, slot_r};

  // ---- memory write controls, decoded from state
  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = {page_r, slot_r};
    lk_wdata = pg_head;
    pg_we    = 1'b0;
    pg_waddr = page_r;
    pg_wdata = pg_rd;
    nx_we    = 1'b0;
    nx_waddr = page_r;
    nx_wdata = head_r;
    pv_we    = 1'b0;
    pv_waddr = page_r;
    pv_wdata = soa_pkg::LIST_EMPTY;
    unique case (state_r)
      S_A_PG: begin
        // last free slot taken: keep the head, zero the count
        if (pg_cnt == soa_pkg::CNT_W'(1)) begin
          pg_we    = 1'b1;
          pg_wdata = {pg_head, soa_pkg::CNT_W'(0)};
        end
      end
      S_A_LK: begin
        pg_we    = 1'b1;
        pg_wdata = {lk_rd, cnt_r};
      end
      S_FRESH: begin
        pg_waddr = free_pg_r;
        pg_wdata = {soa_pkg::LINK_W'(1), n_r - soa_pkg::CNT_W'(1)};
        pg_we    = free_any_r && (n_r != '0);
      end
      S_SWEEP: begin
        lk_waddr = {page_r, idx_r[soa_pkg::SLOT_W-1:0]};
        lk_wdata = soa_pkg::LINK_W'(idx_inc);
        lk_we    = idx_inc < (soa_pkg::CNT_W + 1)'(n_r);
      end
      S_F_PG: begin
        if ({1'b0, slot_r} < n_r && pg_cnt < n_r) begin
          lk_we    = 1'b1;
          pg_we    = 1'b1;
          pg_wdata = {soa_pkg::LINK_W'(slot_r), cnt_inc};
        end
      end
      S_RM2: begin
        nx_waddr = pv_rd[soa_pkg::PG_W-1:0];
        nx_wdata = nx_rd;
        nx_we    = !pv_rd[soa_pkg::PG_W];
        pv_waddr = nx_rd[soa_pkg::PG_W-1:0];
        pv_wdata = pv_rd;
        pv_we    = !nx_rd[soa_pkg::PG_W];
      end
      S_PUSH1: begin
        nx_we = !inl_r[page_r];
        pv_we = !inl_r[page_r];
      end
      S_PUSH2: begin
        pv_waddr = head_r[soa_pkg::PG_W-1:0];
        pv_wdata = soa_pkg::LIST_W'(page_r);
        pv_we    = !head_r[soa_pkg::PG_W];
      end
      default: begin
      end
    endcase
  end

  // ---- sequencer
  always_ff @(posedge clk) begin
    free_pg_r   <= free_pg;
    free_any_r  <= free_any;
    out_valid_r <= 1'b0;
    if (!rst_n) begin
      state_r     <= S_NDIV;
      ret_r       <= S_DONE;
      size_r      <= soa_pkg::SIZE_W'(soa_pkg::MIN_SIZE);
      rem_r       <= '0;
      quo_r       <= soa_pkg::DIV_W'(soa_pkg::PAGE_BYTES);
      step_r      <= '0;
      head_r      <= soa_pkg::LIST_EMPTY;
      cached_v_r  <= 1'b0;
      cached_pg_r <= '0;
      owned_r     <= '0;
      inl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_NDIV: begin
          // advance the 4096 / effective size division one bit
          rem_r  <= rem_step;
          quo_r  <= quo_step;
          step_r <= step_r + soa_pkg::DSTEP_W'(1);
          if (div_last) begin
            n_r     <= (quo_step > soa_pkg::DIV_W'(soa_pkg::MAX_SLOTS)) ?
                       soa_pkg::CNT_W'(soa_pkg::MAX_SLOTS) : soa_pkg::CNT_W'(quo_step);
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          status_r  <= soa_pkg::STATUS_OK;
          rel_r     <= 1'b0;
          addr_en_r <= 1'b0;
          if (cfg_valid) begin
            size_r  <= cfg_object_size;
            rem_r   <= '0;
            quo_r   <= soa_pkg::DIV_W'(soa_pkg::PAGE_BYTES);
            step_r  <= '0;
            state_r <= S_NDIV;
          end else if (start) begin
            if (in_action == soa_pkg::ACT_FREE) begin
              page_r  <= in_address[soa_pkg::ADDR_W-1:soa_pkg::OFF_W];
              rem_r   <= '0;
              quo_r   <= {1'b0, in_address[soa_pkg::OFF_W-1:0]};
              step_r  <= '0;
              state_r <= S_F_DIV;
            end else if (cached_v_r) begin
              page_r     <= cached_pg_r;
              cached_v_r <= 1'b0;
              state_r    <= S_A_PGRD;
            end else if (!head_r[soa_pkg::PG_W]) begin
              page_r  <= head_r[soa_pkg::PG_W-1:0];
              ret_r   <= S_A_PGRD;
              state_r <= S_RM1;
            end else begin
              state_r <= S_FRESH;
            end
          end
        end
        S_A_PGRD: state_r <= S_A_PG;
        S_A_PG: begin
          if (pg_cnt != '0) begin
            slot_r    <= pg_head[soa_pkg::SLOT_W-1:0];
            cnt_r     <= pg_cnt - soa_pkg::CNT_W'(1);
            addr_en_r <= 1'b1;
            state_r   <= (pg_cnt == soa_pkg::CNT_W'(1)) ? S_MUL : S_A_LKRD;
          end else begin
            state_r <= S_FRESH;
          end
        end
        S_A_LKRD: state_r <= S_A_LK;
        S_A_LK: begin
          ret_r   <= S_MUL;
          state_r <= S_PUSH1;
        end
        S_FRESH: begin
          if (n_r == '0 || !free_any_r) begin
            status_r <= soa_pkg::STATUS_FAIL;
            state_r  <= S_DONE;
          end else begin
            page_r            <= free_pg_r;
            owned_r[free_pg_r] <= 1'b1;
            slot_r            <= '0;
            idx_r             <= soa_pkg::CNT_W'(1);
            addr_en_r         <= 1'b1;
            state_r           <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          // link slots 1..n-1 in ascending order, one per cycle
          if (idx_inc < (soa_pkg::CNT_W + 1)'(n_r)) begin
            idx_r <= idx_inc[soa_pkg::CNT_W-1:0];
          end else if (n_r > soa_pkg::CNT_W'(1)) begin
            ret_r   <= S_MUL;
            state_r <= S_PUSH1;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_F_DIV: begin
          rem_r  <= rem_step;
          quo_r  <= quo_step;
          step_r <= step_r + soa_pkg::DSTEP_W'(1);
          if (div_last) begin
            slot_r  <= quo_step[soa_pkg::SLOT_W-1:0];
            state_r <= (!owned_r[page_r] || (cached_v_r && cached_pg_r == page_r)) ?
                       S_DONE : S_F_PGRD;
          end
        end
        S_F_PGRD: state_r <= S_F_PG;
        S_F_PG: begin
          if ({1'b0, slot_r} >= n_r || pg_cnt >= n_r) begin
            state_r <= S_DONE;
          end else if (cnt_inc == n_r) begin
            ret_r   <= S_F_REL;
            state_r <= S_RM1;
          end else if (cnt_inc == soa_pkg::CNT_W'(1)) begin
            ret_r   <= S_DONE;
            state_r <= S_PUSH1;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_F_REL: begin
          // wholly free page: cache it, or hand it back to the pool
          if (!cached_v_r) begin
            cached_v_r  <= 1'b1;
            cached_pg_r <= page_r;
          end else begin
            owned_r[page_r] <= 1'b0;
            rel_r           <= 1'b1;
          end
          state_r <= S_DONE;
        end
        S_RM1: state_r <= inl_r[page_r] ? S_RM2 : ret_r;
        S_RM2: begin
          if (pv_rd[soa_pkg::PG_W]) begin
            head_r <= nx_rd;
          end
          inl_r[page_r] <= 1'b0;
          state_r       <= ret_r;
        end
        S_PUSH1: state_r <= inl_r[page_r] ? ret_r : S_PUSH2;
        S_PUSH2: begin
          head_r        <= soa_pkg::LIST_W'(page_r);
          inl_r[page_r] <= 1'b1;
          state_r       <= ret_r;
        end
        S_MUL: begin
          prod_r  <= soa_pkg::PROD_W'(slot_r) * soa_pkg::PROD_W'(eff);
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid_r  <= 1'b1;
          out_status_r <= status_r;
          out_rel_r    <= rel_r;
          out_addr_r   <= addr_en_r ?
                          soa_pkg::ADDR_W'({page_r, soa_pkg::OFF_W'(0)}) +
                          prod_r[soa_pkg::ADDR_W-1:0] : '0;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy               = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready          = state_r == S_IDLE;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_object_address = out_addr_r;
  assign out_page_released  = out_rel_r;

  // ---- checks
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back result strobes");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("transaction taken without busy");

  a_cache_off_list: assert property (@(posedge clk) disable iff (!rst_n)
    cached_v_r |-> !inl_r[cached_pg_r]) else $error("cached page on partial list");

  a_head_listed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !head_r[soa_pkg::PG_W]) |-> inl_r[head_r[soa_pkg::PG_W-1:0]])
    else $error("partial head not marked listed");

  a_release_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_page_released) |->
      (out_status == soa_pkg::STATUS_OK && out_object_address == '0))
    else $error("release flagged on an allocation");

endmodule
